[hw/rtl/websocket_frame_deframer_defines.svh]
// assertion macros shared by the websocket deframer checkers
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked on every clk edge outside reset
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wsfd_pkg.sv]
// package: phase codes, opcodes, message kinds and the result record of the deframer
`default_nettype none

package wsfd_pkg;

  // parse phases
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  // opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  // message kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_BINARY = 2'd2;

  // 7-bit length escape codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended length and key field sizes in bytes
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic [3:0] opcode;
    logic [1:0] kind;
    logic [2:0] rsv;
    logic       frame_end;
    logic       message_end;
    logic       close_seen;
    logic       ping_seen;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/websocket_frame_deframer.sv]
// top level: websocket (rfc 6455 receive side) frame deframer, one byte per transaction
//
// usage
//   input channel: one raw stream byte per transaction on in_byte (in_valid / in_stall)
//   header bytes (two header bytes, 16/64-bit extended length, 4-byte masking key)
//   produce no output; each payload byte produces one output transaction carrying
//   the unmasked byte plus frame opcode, message kind, rsv bits and end flags
//   a zero-length frame produces one marker transaction with out_has_byte low
//   result: the result of an accepted byte is registered into the output register,
//   or into the skid register while the output register holds a stalled result
//   throughput: one byte every cycle while in_stall is low, set by the single
//   registered parse step; the 64-bit length decrement and end compare is
//   the longest path
//   stall: a one-entry skid register catches a result while out_stall is high;
//   in_stall is high while it is full, so no result is lost or repeated
//   reset (rst_n low, synchronous): parser back to the first header byte,
//   no message kind remembered, output and skid registers empty
`default_nettype none

module websocket_frame_deframer
  import wsfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic [3:0]      out_frame_opcode,
  output logic [1:0]      out_message_kind,
  output logic [2:0]      out_rsv_bits,
  output logic            out_frame_end,
  output logic            out_message_end,
  output logic            out_close_seen,
  output logic            out_ping_seen
);

  // parser state
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;            // fin, rsv1..3, opcode
  logic        mask_r, mask_nxt;
  logic [63:0] rem_r, rem_nxt;            // payload bytes left, or length being built
  logic [3:0]  fcnt_r, fcnt_nxt;          // bytes left in extended length or key
  logic [31:0] key_r, key_nxt;            // first key byte in [31:24]
  logic [1:0]  kidx_r, kidx_nxt;
  logic [1:0]  last_kind_r, last_kind_nxt;

  // output register and skid register
  res_t        out_r, skid_r, res_nxt;
  logic        out_valid_r, skid_valid_r;

  logic        in_acc;
  logic        out_pop;
  logic        produce;
  logic        res_push;
  logic [3:0]  cur_op;
  logic [1:0]  cur_kind;
  logic        frame_end;
  logic [7:0]  key_byte;
  logic [6:0]  len7;

  // handshakes: input stalls only while the skid register holds a result
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_pop  = out_valid_r && !out_stall;
  assign res_push = in_acc && produce;

  // kind of the frame in progress; continuation inherits the last data kind
  assign cur_op = hdr_r[3:0];
  always_comb begin
    case (cur_op)
      OP_TEXT:   cur_kind = KIND_TEXT;
      OP_BINARY: cur_kind = KIND_BINARY;
      OP_CONT:   cur_kind = last_kind_r;
      default:   cur_kind = KIND_NONE;
    endcase
  end

  // key byte for the next payload byte: index 0 takes bits 31..24
  assign key_byte = key_r[{~kidx_r, 3'b000} +: 8];
  assign len7     = in_byte[6:0];

  // one parse step for the byte on in_byte
  always_comb begin
    phase_nxt     = phase_r;
    hdr_nxt       = hdr_r;
    mask_nxt      = mask_r;
    rem_nxt       = rem_r;
    fcnt_nxt      = fcnt_r;
    key_nxt       = key_r;
    kidx_nxt      = kidx_r;
    last_kind_nxt = last_kind_r;
    produce       = 1'b0;
    frame_end     = 1'b0;
    res_nxt.data     = 8'd0;
    res_nxt.has_byte = 1'b0;

    case (phase_r)
      PH_HDR1: begin
        mask_nxt = in_byte[7];
        key_nxt  = 32'd0;
        kidx_nxt = 2'd0;
        rem_nxt  = 64'd0;
        if (len7 == LEN_EXT16) begin
          fcnt_nxt  = EXT16_BYTES;
          phase_nxt = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          fcnt_nxt  = EXT64_BYTES;
          phase_nxt = PH_EXT;
        end else begin
          rem_nxt = {57'd0, len7};
          if (in_byte[7]) begin
            fcnt_nxt  = KEY_BYTES;
            phase_nxt = PH_KEY;
          end else if (len7 == 7'd0) begin
            // empty frame: marker result
            produce   = 1'b1;
            frame_end = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        rem_nxt = {rem_r[55:0], in_byte};
        if (fcnt_r <= 4'd1) begin
          fcnt_nxt = 4'd0;
          if (mask_r) begin
            fcnt_nxt  = KEY_BYTES;
            phase_nxt = PH_KEY;
          end else begin
            kidx_nxt = 2'd0;
            if (rem_nxt == 64'd0) begin
              produce   = 1'b1;
              frame_end = 1'b1;
              phase_nxt = PH_HDR0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end else begin
          fcnt_nxt = fcnt_r - 4'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], in_byte};
        if (fcnt_r <= 4'd1) begin
          fcnt_nxt = 4'd0;
          kidx_nxt = 2'd0;
          if (rem_r == 64'd0) begin
            produce   = 1'b1;
            frame_end = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end else begin
          fcnt_nxt = fcnt_r - 4'd1;
        end
      end
      PH_DATA: begin
        res_nxt.data     = mask_r ? (in_byte ^ key_byte) : in_byte;
        res_nxt.has_byte = 1'b1;
        kidx_nxt         = kidx_r + 2'd1;
        rem_nxt          = rem_r - 64'd1;
        produce          = 1'b1;
        frame_end        = (rem_r == 64'd1);
        if (rem_r == 64'd1) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        // first header byte; unused phase codes land here too
        hdr_nxt = in_byte;
        if (in_byte[3:0] == OP_TEXT || in_byte[3:0] == OP_BINARY) begin
          last_kind_nxt = in_byte[1:0];
        end
        phase_nxt = PH_HDR1;
      end
    endcase

    // frame-level fields come from the header stored earlier
    res_nxt.opcode      = cur_op;
    res_nxt.kind        = cur_kind;
    res_nxt.rsv         = hdr_r[6:4];
    res_nxt.frame_end   = frame_end;
    res_nxt.message_end = frame_end && hdr_r[7] && (cur_kind != KIND_NONE);
    res_nxt.close_seen  = frame_end && (cur_op == OP_CLOSE);
    res_nxt.ping_seen   = frame_end && (cur_op == OP_PING);
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      hdr_r       <= 8'd0;
      mask_r      <= 1'b0;
      rem_r       <= 64'd0;
      fcnt_r      <= 4'd0;
      key_r       <= 32'd0;
      kidx_r      <= 2'd0;
      last_kind_r <= KIND_NONE;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      hdr_r       <= hdr_nxt;
      mask_r      <= mask_nxt;
      rem_r       <= rem_nxt;
      fcnt_r      <= fcnt_nxt;
      key_r       <= key_nxt;
      kidx_r      <= kidx_nxt;
      last_kind_r <= last_kind_nxt;
    end
  end

  // output / skid valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // drain skid into the output register
      if (out_pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // output / skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (res_push) begin
      if (!out_valid_r || out_pop) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_r.data;
  assign out_has_byte     = out_r.has_byte;
  assign out_frame_opcode = out_r.opcode;
  assign out_message_kind = out_r.kind;
  assign out_rsv_bits     = out_r.rsv;
  assign out_frame_end    = out_r.frame_end;
  assign out_message_end  = out_r.message_end;
  assign out_close_seen   = out_r.close_seen;
  assign out_ping_seen    = out_r.ping_seen;

endmodule

`default_nettype wire

[hw/rtl/wsfd_checker.sv]
// checker on the deframer ports, with its bind to the top level
`default_nettype none

`include "websocket_frame_deframer_defines.svh"

module wsfd_checker
  import wsfd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_has_byte,
  input wire logic [3:0] out_frame_opcode,
  input wire logic [1:0] out_message_kind,
  input wire logic       out_frame_end,
  input wire logic       out_message_end,
  input wire logic       out_close_seen,
  input wire logic       out_ping_seen
);

  // a stalled result stays offered with the same byte
  `WSFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled result changed")

  // empty-frame marker carries a zero byte and closes the frame
  `WSFD_ASSERT_NOW(a_marker, out_valid && !out_has_byte, (out_byte == 8'd0) && out_frame_end, "bad empty-frame marker")

  // message end only on the last result of a data frame
  `WSFD_ASSERT_NOW(a_msg_end, out_valid && out_message_end, out_frame_end && (out_message_kind != KIND_NONE), "message end off a data frame end")

  // close and ping flags match the opcode at frame end
  `WSFD_ASSERT_NOW(a_ctrl, out_valid && (out_close_seen || out_ping_seen), out_frame_end && (out_close_seen ? (out_frame_opcode == OP_CLOSE) : (out_frame_opcode == OP_PING)), "control flag mismatch")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);

`default_nettype wire
